// ===== design/q24_pkg.sv =====
// package for the q24.8 fixed-point alu: opcodes and shared types
package q24_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_INC = 4'd4,
        OP_DEC = 4'd5,
        OP_GT  = 4'd6,
        OP_LT  = 4'd7,
        OP_GE  = 4'd8,
        OP_LE  = 4'd9,
        OP_EQ  = 4'd10,
        OP_NE  = 4'd11,
        OP_MIN = 4'd12,
        OP_MAX = 4'd13,
        OP_ITF = 4'd14,
        OP_FTI = 4'd15
    } op_t;

    localparam int WORD_W = 32;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

endpackage

// ===== design/q24_div.sv =====
// pipelined restoring divider on magnitudes, one quotient bit per stage
module q24_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);
    import q24_pkg::*;

    logic [NUM_W-1:0] q_reg [1:NUM_W];
    logic [DEN_W-1:0] d_reg [1:NUM_W];
    logic [DEN_W:0]   r_reg [1:NUM_W];

    // stage k brings down one dividend bit and tries one subtraction
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] q_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W:0]   r_in;
        logic [DEN_W:0]   sh;
        logic [DEN_W:0]   diff;
        logic             ok;
        if (k == 0) begin : g_head
            assign q_in = num;
            assign d_in = den;
            assign r_in = '0;
        end else begin : g_body
            assign q_in = q_reg[k];
            assign d_in = d_reg[k];
            assign r_in = r_reg[k];
        end
        always_comb begin
            sh   = {r_in[DEN_W-1:0], q_in[NUM_W-1]};
            diff = sh - {1'b0, d_in};
            ok   = (sh >= {1'b0, d_in});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1] <= ok ? diff : sh;
                q_reg[k+1] <= {q_in[NUM_W-2:0], ok};
                d_reg[k+1] <= d_in;
            end
        end
    end

    assign quo = q_reg[NUM_W];
endmodule

// ===== design/q24_8_fixed_point_alu.sv =====
// q24.8 saturating fixed-point alu, top level
// One beat in, one beat out, in order, at a sustained rate of one beat per clock while m_ready
// does not stall. All opcodes travel the same pipeline, whose length is set by the divider,
// which retires one quotient bit per stage over a 32 + FRAC_W bit dividend, plus one sign and
// saturation stage and one output stage. A stall on m_ready freezes the whole pipeline;
// s_ready is high whenever the output stage is empty or being taken. Multiply uses one 32x32
// signed multiplier whose product is registered before the shift and saturation stage.
module q24_8_fixed_point_alu #(
    parameter int FRAC_W = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_cmd,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result,
    output logic               m_compare_true
);
    import q24_pkg::*;

    localparam int NUM_W = WORD_W + FRAC_W;
    localparam int DLAT  = NUM_W;
    localparam int DEPTH = DLAT + 2;

    logic en;
    logic vld_reg [DEPTH];

    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;

    // stage 1: simple ops, multiplier, divider setup
    logic signed [63:0]      prod1_reg;
    logic [NUM_W-1:0]        dnum;
    logic [31:0]             dden;

    logic signed [31:0]      simp_c;
    logic                    cmp_c;
    logic signed [32:0]      a_ext;
    logic signed [32:0]      b_ext;

    always_comb begin
        a_ext  = {s_operand_a[31], s_operand_a};
        b_ext  = {s_operand_b[31], s_operand_b};
        simp_c = '0;
        cmp_c  = 1'b0;
        case (op_t'(s_cmd))
            OP_ADD: simp_c = s_operand_a + s_operand_b;
            OP_SUB: simp_c = s_operand_a - s_operand_b;
            OP_INC: simp_c = (s_operand_a == WORD_MAX) ? WORD_MAX : s_operand_a + 32'sd1;
            OP_DEC: simp_c = (s_operand_a == WORD_MIN) ? WORD_MIN : s_operand_a - 32'sd1;
            OP_GT:  cmp_c  = s_operand_a > s_operand_b;
            OP_LT:  cmp_c  = s_operand_a < s_operand_b;
            OP_GE:  cmp_c  = s_operand_a >= s_operand_b;
            OP_LE:  cmp_c  = s_operand_a <= s_operand_b;
            OP_EQ:  cmp_c  = s_operand_a == s_operand_b;
            OP_NE:  cmp_c  = s_operand_a != s_operand_b;
            OP_MIN: simp_c = (s_operand_a <= s_operand_b) ? s_operand_a : s_operand_b;
            OP_MAX: simp_c = (s_operand_a >= s_operand_b) ? s_operand_a : s_operand_b;
            OP_ITF: simp_c = s_operand_a <<< FRAC_W;
            OP_FTI: simp_c = s_operand_a >>> FRAC_W;
            default: simp_c = '0;
        endcase
        // magnitudes for the divider
        dnum = NUM_W'(s_operand_a[31] ? -a_ext : a_ext) << FRAC_W;
        dden = 32'(s_operand_b[31] ? -b_ext : b_ext);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod1_reg <= s_operand_a * s_operand_b;
        end
    end

    // stage 2: multiply saturation; then delay line to match the divider
    logic signed [31:0] mres2_reg;
    logic signed [63:0] psh;
    always_comb psh = prod1_reg >>> FRAC_W;
    always_ff @(posedge aclk) begin
        if (en) begin
            if (psh > 64'(WORD_MAX))
                mres2_reg <= WORD_MAX;
            else if (psh < 64'(WORD_MIN))
                mres2_reg <= WORD_MIN;
            else
                mres2_reg <= psh[31:0];
        end
    end

    logic [NUM_W-1:0] quo;
    q24_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
        .aclk(aclk), .en(en), .num(dnum), .den(dden), .quo(quo)
    );

    // side data travels alongside the divider stages
    op_t                op_d   [DLAT];
    logic signed [31:0] simp_d [DLAT];
    logic               cmp_d  [DLAT];
    logic               neg_d  [DLAT];
    logic               dz_d   [DLAT];
    always_ff @(posedge aclk) begin
        if (en) begin
            op_d[0]   <= op_t'(s_cmd);
            simp_d[0] <= simp_c;
            cmp_d[0]  <= cmp_c;
            neg_d[0]  <= s_operand_a[31] ^ s_operand_b[31];
            dz_d[0]   <= (s_operand_b == 32'sd0);
            for (int i = 1; i < DLAT; i++) begin
                op_d[i]   <= op_d[i-1];
                // mres2_reg holds the product of the beat in op_d[1]
                simp_d[i] <= (i == 2) ? ((op_d[1] == OP_MUL) ? mres2_reg : simp_d[1])
                                      : simp_d[i-1];
                cmp_d[i]  <= cmp_d[i-1];
                neg_d[i]  <= neg_d[i-1];
                dz_d[i]   <= dz_d[i-1];
            end
        end
    end

    // stage after divider: sign and saturation of the quotient
    logic signed [31:0] dres_reg;
    op_t                opx_reg;
    logic signed [31:0] simpx_reg;
    logic               cmpx_reg;
    logic [NUM_W:0]     qmag;
    always_comb qmag = {1'b0, quo};
    always_ff @(posedge aclk) begin
        if (en) begin
            opx_reg   <= op_d[DLAT-1];
            simpx_reg <= simp_d[DLAT-1];
            cmpx_reg  <= cmp_d[DLAT-1];
            if (dz_d[DLAT-1])
                dres_reg <= '0;
            else if (!neg_d[DLAT-1])
                dres_reg <= (qmag > (NUM_W+1)'(WORD_MAX)) ? WORD_MAX : quo[31:0];
            else
                dres_reg <= (qmag > (NUM_W+1)'(33'h0_8000_0000)) ? WORD_MIN
                                                                 : -quo[31:0];
        end
    end

    // output stage
    logic signed [31:0] res_reg;
    logic               cmpo_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg  <= (opx_reg == OP_DIV) ? dres_reg : simpx_reg;
            cmpo_reg <= cmpx_reg;
        end
    end

    // valid chain: s stage1 ... matches the data path depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < DEPTH; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // data depth: op_d[0] at 1, op_d[DLAT-1] at DLAT, opx at DLAT+1, res at DLAT+2
    assign m_valid        = vld_reg[DEPTH-1];
    assign m_result       = res_reg;
    assign m_compare_true = cmpo_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result) && $stable(m_compare_true))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_true |-> m_result == 32'sd0)
        else $error("comparison with nonzero result");
endmodule

// ===== tb/sv/tb_q24_8_fixed_point_alu.sv =====
// testbench for the q24.8 saturating fixed-point alu: directed table then random beats
`timescale 1ns / 1ps

module tb_q24_8_fixed_point_alu;
    import q24_pkg::*;

    localparam int FRAC      = 8;
    localparam int LATENCY   = FRAC + 34;
    localparam int N_RANDOM  = 1030;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        op_t         op;
        logic [31:0] a;
        logic [31:0] b;
        bit          known;
        logic [31:0] res;
        logic        cmp;
    } alu_row_t;

    typedef struct {
        logic [31:0] res;
        logic        cmp;
    } alu_out_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_cmd = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_result;
    logic               m_compare_true;

    alu_out_t expected_q[$];
    int       errors = 0;
    int       results_seen = 0;
    longint   cycles = 0;
    int       idle_pct_s = 0;
    int       stall_pct_m = 0;
    bit       op_seen[16];

    q24_8_fixed_point_alu #(.FRAC_W(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result(m_result), .m_compare_true(m_compare_true)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [31:0] clamp_word(logic signed [65:0] x);
        if (x > 66'sd2147483647) return WORD_MAX;
        if (x < -66'sd2147483648) return WORD_MIN;
        return x[31:0];
    endfunction

    function automatic alu_out_t alu_compute(op_t op, logic [31:0] ua, logic [31:0] ub);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [65:0] wide;
        logic signed [65:0] num;
        alu_out_t o;
        a = ua;
        b = ub;
        o.res = '0;
        o.cmp = 1'b0;
        case (op)
            OP_ADD: o.res = ua + ub;
            OP_SUB: o.res = ua - ub;
            OP_MUL: begin
                wide = 66'(a) * 66'(b);
                o.res = clamp_word(wide >>> FRAC);
            end
            OP_DIV: begin
                if (b != 0) begin
                    // signed division truncates toward zero
                    num = 66'(a) <<< FRAC;
                    o.res = clamp_word(num / 66'(b));
                end
            end
            OP_INC: o.res = clamp_word(66'(a) + 66'sd1);
            OP_DEC: o.res = clamp_word(66'(a) - 66'sd1);
            OP_GT:  o.cmp = a > b;
            OP_LT:  o.cmp = a < b;
            OP_GE:  o.cmp = a >= b;
            OP_LE:  o.cmp = a <= b;
            OP_EQ:  o.cmp = a == b;
            OP_NE:  o.cmp = a != b;
            OP_MIN: o.res = (a <= b) ? a : b;
            OP_MAX: o.res = (a >= b) ? a : b;
            OP_ITF: o.res = ua << FRAC;
            default: o.res = a >>> FRAC;
        endcase
        return o;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return WORD_MAX - $urandom_range(0, 3);
            1: return WORD_MIN + $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // drive one beat and hold until accepted; valid drops only on idle cycles
    task automatic send_beat(op_t op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(0, 99) < idle_pct_s) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // expectations are queued at acceptance so ordering follows the handshake
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_q.push_back(alu_compute(op_t'(s_cmd), s_operand_a, s_operand_b));
            op_seen[s_cmd] = 1'b1;
        end
    end

    always @(posedge aclk) begin
        alu_out_t exp_o;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: result=%h", m_result);
                errors++;
            end else begin
                exp_o = expected_q.pop_front();
                if (m_result !== exp_o.res) begin
                    $error("result: expected %h actual %h", exp_o.res, m_result);
                    errors++;
                end
                if (m_compare_true !== exp_o.cmp) begin
                    $error("compare_true: expected %b actual %b", exp_o.cmp, m_compare_true);
                    errors++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct_m);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("q24_8_fixed_point_alu: mismatch");
            $finish;
        end
    end

    alu_row_t rows[$];

    task automatic add_row(op_t op, logic [31:0] a, logic [31:0] b, bit known,
                           logic [31:0] res, logic cmp);
        alu_row_t r;
        r.op = op; r.a = a; r.b = b; r.known = known; r.res = res; r.cmp = cmp;
        rows.push_back(r);
    endtask

    initial begin
        alu_out_t got;
        op_t op;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(OP_ADD, WORD_MAX, 32'd1, 1, WORD_MIN, 0);        // add wraps
        add_row(OP_SUB, WORD_MIN, 32'd1, 1, WORD_MAX, 0);        // sub wraps
        add_row(OP_MUL, WORD_MAX, WORD_MAX, 1, WORD_MAX, 0);     // mul saturates high
        add_row(OP_MUL, WORD_MIN, WORD_MAX, 1, WORD_MIN, 0);     // mul saturates low
        add_row(OP_MUL, 32'hFFFF_FFFF, 32'd1, 1, 32'hFFFF_FFFF, 0); // floor shift
        add_row(OP_DIV, 32'd1234, 32'd0, 1, 32'd0, 0);           // divide by zero
        add_row(OP_DIV, WORD_MAX, 32'd1, 1, WORD_MAX, 0);
        add_row(OP_DIV, WORD_MIN, 32'd1, 1, WORD_MIN, 0);
        add_row(OP_DIV, -32'sd7, 32'd2048, 0, 0, 0);             // truncation toward zero
        add_row(OP_INC, WORD_MAX, 32'd0, 1, WORD_MAX, 0);
        add_row(OP_DEC, WORD_MIN, 32'd0, 1, WORD_MIN, 0);
        add_row(OP_GT, WORD_MAX, WORD_MIN, 1, 32'd0, 1);
        add_row(OP_LT, WORD_MAX, WORD_MIN, 1, 32'd0, 0);
        add_row(OP_GE, 32'd5, 32'd5, 1, 32'd0, 1);
        add_row(OP_LE, WORD_MIN, WORD_MIN, 1, 32'd0, 1);
        add_row(OP_EQ, 32'd5, 32'd6, 1, 32'd0, 0);
        add_row(OP_NE, 32'd5, 32'd6, 1, 32'd0, 1);
        add_row(OP_MIN, 32'd77, 32'd77, 1, 32'd77, 0);           // equal operands
        add_row(OP_MAX, WORD_MIN, WORD_MAX, 1, WORD_MAX, 0);
        add_row(OP_ITF, WORD_MAX, 32'd0, 1, 32'hFFFF_FF00, 0);   // wraps
        add_row(OP_FTI, WORD_MIN, 32'd0, 1, 32'hFF80_0000, 0);
        add_row(OP_FTI, 32'hFFFF_FFFF, WORD_MAX, 1, 32'hFFFF_FFFF, 0);

        foreach (rows[i]) begin
            if (rows[i].known) begin
                got = alu_compute(rows[i].op, rows[i].a, rows[i].b);
                if (got.res !== rows[i].res || got.cmp !== rows[i].cmp) begin
                    $error("table row %0d: predictor %h/%b, table %h/%b", i,
                           got.res, got.cmp, rows[i].res, rows[i].cmp);
                    errors++;
                end
            end
            send_beat(rows[i].op, rows[i].a, rows[i].b);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            case ((i * 5) / N_RANDOM)
                0: begin idle_pct_s = 0;  stall_pct_m = 0;  end
                1: begin idle_pct_s = 62; stall_pct_m = 0;  end
                2: begin idle_pct_s = 0;  stall_pct_m = 62; end
                3: begin idle_pct_s = 7;  stall_pct_m = 7;  end
                default: begin idle_pct_s = 0; stall_pct_m = 0; end
            endcase
            op = op_t'($urandom_range(0, 15));
            send_beat(op, rand_word(), ($urandom_range(0, 15) == 0) ? 32'd0 : rand_word());
        end
        s_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        $display("covered %0d beats in, %0d results out, all 16 opcodes seen: %0d",
                 rows.size() + N_RANDOM, results_seen, op_seen.and());
        $display("idle and stall phases run: none, sender, receiver, light both");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("q24_8_fixed_point_alu: match");
        end else begin
            $display("q24_8_fixed_point_alu: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/q24_pkg.sv
design/q24_div.sv
design/q24_8_fixed_point_alu.sv
tb/sv/tb_q24_8_fixed_point_alu.sv
